// ===== rtl/lpfd_pkg.sv =====
// ============================================================================
// Length-prefixed frame decoder package
// Shared constants, status codes and the result record of the decoder.
// ============================================================================
`default_nettype none

package lpfd_pkg;

    // Number of little-endian bytes in a frame length header (1 to 4).
    localparam int unsigned HEADER_BYTES = 4;
    localparam int unsigned HDR_CNT_W    = 3;
    localparam int unsigned LEN_W        = 32;
    localparam int unsigned BYTE_W       = 8;

    localparam logic [HDR_CNT_W-1:0] HDR_LAST_CNT = HDR_CNT_W'(HEADER_BYTES);
    localparam logic [LEN_W-1:0]     MAX_LEN_RESET = LEN_W'(1048576);

    typedef enum logic [1:0] {
        ST_PAYLOAD   = 2'd0,
        ST_EMPTY     = 2'd1,
        ST_TOO_LARGE = 2'd2,
        ST_TRUNCATED = 2'd3
    } t_status;

    typedef enum logic {
        ACT_DATA = 1'b0,
        ACT_EOS  = 1'b1
    } t_action;

    typedef struct packed {
        t_status             status;
        logic [BYTE_W-1:0]   payload_byte;
        logic                last;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/length_prefixed_frame_decoder.sv =====
// ============================================================================
// Length-prefixed frame decoder
// Strips 32-bit little-endian length headers from a byte stream and passes
// the payload bytes through, reporting bad lengths and truncated frames.
// ============================================================================
// An accepted byte is held in the input register, then the frame state and
// the result register are updated together. Throughput: one byte per cycle
// unless the receiver stalls; the frame state is a per-byte update.
// Reset: synchronous, active low; clears the frame state and the valid flags
// of both registers and loads the maximum payload length with 1048576.
`default_nettype none

module length_prefixed_frame_decoder (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_stall,
    input  wire logic                          i_action,
    input  wire logic [lpfd_pkg::BYTE_W-1:0]   i_data_byte,
    output logic                               o_valid,
    input  wire logic                          i_stall,
    output logic [1:0]                         o_status,
    output logic [lpfd_pkg::BYTE_W-1:0]        o_payload_byte,
    output logic                               o_last,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [lpfd_pkg::LEN_W-1:0]    i_cfg_data
);

    logic                              r_in_valid;
    logic                              r_action;
    logic [lpfd_pkg::BYTE_W-1:0]       r_data_byte;
    logic [lpfd_pkg::LEN_W-1:0]        r_max_len;

    logic                              advance;
    logic                              step;
    logic                              res_valid;
    lpfd_pkg::t_result                 res;
    lpfd_pkg::t_result                 out_res;

    assign o_cfg_ready = 1'b1;
    assign step        = r_in_valid && advance;
    assign o_stall     = r_in_valid && !advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= lpfd_pkg::MAX_LEN_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_max_len <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_action    <= i_action;
            r_data_byte <= i_data_byte;
        end
    end

    lpfd_frame_fsm u_frame (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_step      (step),
        .i_action    (r_action),
        .i_data_byte (r_data_byte),
        .i_max_len   (r_max_len),
        .o_res       (res),
        .o_res_valid (res_valid)
    );

    lpfd_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_stall   (i_stall),
        .i_load    (r_in_valid),
        .i_valid   (res_valid),
        .i_res     (res),
        .o_advance (advance),
        .o_valid   (o_valid),
        .o_res     (out_res)
    );

    assign o_status       = out_res.status;
    assign o_payload_byte = out_res.payload_byte;
    assign o_last         = out_res.last;

endmodule

`default_nettype wire

// ===== rtl/lpfd_frame_fsm.sv =====
// ============================================================================
// Frame tracker
// Collects the length header, checks it, and counts payload bytes down.
// ============================================================================
`default_nettype none

module lpfd_frame_fsm (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_step,
    input  wire logic                          i_action,
    input  wire logic [lpfd_pkg::BYTE_W-1:0]   i_data_byte,
    input  wire logic [lpfd_pkg::LEN_W-1:0]    i_max_len,
    output lpfd_pkg::t_result                  o_res,
    output logic                               o_res_valid
);

    logic                              r_in_payload, n_in_payload;
    logic [lpfd_pkg::HDR_CNT_W-1:0]    r_hdr_cnt,    n_hdr_cnt;
    logic [lpfd_pkg::LEN_W-1:0]        r_len_accum,  n_len_accum;
    logic [lpfd_pkg::LEN_W-1:0]        r_remaining,  n_remaining;

    logic [lpfd_pkg::LEN_W-1:0]        hdr_len;
    logic [lpfd_pkg::HDR_CNT_W-1:0]    hdr_cnt_inc;
    logic                              is_last;

    always_comb begin
        hdr_cnt_inc = r_hdr_cnt + lpfd_pkg::HDR_CNT_W'(1);
        hdr_len     = r_len_accum |
                      (lpfd_pkg::LEN_W'(i_data_byte) << {r_hdr_cnt[1:0], 3'b000});
        is_last     = (r_remaining <= lpfd_pkg::LEN_W'(1));
    end

    always_comb begin
        n_in_payload = r_in_payload;
        n_hdr_cnt    = r_hdr_cnt;
        n_len_accum  = r_len_accum;
        n_remaining  = r_remaining;
        o_res_valid  = 1'b0;
        o_res.status       = lpfd_pkg::ST_PAYLOAD;
        o_res.payload_byte = '0;
        o_res.last         = 1'b0;

        if (i_action == lpfd_pkg::ACT_EOS) begin
            o_res_valid  = r_in_payload || (r_hdr_cnt != '0);
            o_res.status = lpfd_pkg::ST_TRUNCATED;
            n_in_payload = 1'b0;
            n_hdr_cnt    = '0;
            n_len_accum  = '0;
            n_remaining  = '0;
        end else if (r_in_payload) begin
            o_res_valid        = 1'b1;
            o_res.payload_byte = i_data_byte;
            o_res.last         = is_last;
            if (is_last) begin
                n_in_payload = 1'b0;
                n_remaining  = '0;
            end else begin
                n_remaining = r_remaining - lpfd_pkg::LEN_W'(1);
            end
        end else if (hdr_cnt_inc == lpfd_pkg::HDR_LAST_CNT) begin
            // Header complete: either reject it or open the payload.
            n_hdr_cnt   = '0;
            n_len_accum = '0;
            if (hdr_len == '0) begin
                o_res_valid  = 1'b1;
                o_res.status = lpfd_pkg::ST_EMPTY;
            end else if (hdr_len > i_max_len) begin
                o_res_valid  = 1'b1;
                o_res.status = lpfd_pkg::ST_TOO_LARGE;
            end else begin
                n_in_payload = 1'b1;
                n_remaining  = hdr_len;
            end
        end else begin
            n_hdr_cnt   = hdr_cnt_inc;
            n_len_accum = hdr_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_hdr_cnt    <= '0;
            r_len_accum  <= '0;
            r_remaining  <= '0;
        end else if (i_step) begin
            r_in_payload <= n_in_payload;
            r_hdr_cnt    <= n_hdr_cnt;
            r_len_accum  <= n_len_accum;
            r_remaining  <= n_remaining;
        end
    end

    // A payload in progress always has at least one byte left to come.
    a_payload_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_remaining != '0))
        else $error("payload active with zero remaining bytes");

    // Header collection and payload counting never overlap.
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_hdr_cnt == '0))
        else $error("header count nonzero inside payload");

    // The final payload byte returns the tracker to header collection.
    a_last_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && o_res_valid && o_res.last) |=> !r_in_payload)
        else $error("frame still open after last byte");

endmodule

`default_nettype wire

// ===== rtl/lpfd_out_reg.sv =====
// ============================================================================
// Result register
// Holds one decoded result until the downstream side takes it.
// ============================================================================
`default_nettype none

module lpfd_out_reg (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_stall,
    input  wire logic               i_load,
    input  wire logic               i_valid,
    input  wire lpfd_pkg::t_result  i_res,
    output logic                    o_advance,
    output logic                    o_valid,
    output lpfd_pkg::t_result       o_res
);

    logic              r_valid;
    lpfd_pkg::t_result r_res;

    // The register can take a new value when it is empty or being drained.
    assign o_advance = !r_valid || !i_stall;
    assign o_valid   = r_valid;
    assign o_res     = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_load && i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance && i_load && i_valid) begin
            r_res <= i_res;
        end
    end

endmodule

`default_nettype wire

// ===== dv/frame_decode_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame decoder checker
// Watches the byte, result and configuration channels of the length-prefixed
// frame decoder, predicts every result from the accepted bytes and compares
// the results field by field in order.
// ----------------------------------------------------------------------------

module frame_decode_checker (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_byte_valid,
    input  wire logic                          i_byte_stall,
    input  wire logic                          i_action,
    input  wire logic [lpfd_pkg::BYTE_W-1:0]   i_data_byte,
    input  wire logic                          i_res_valid,
    input  wire logic                          i_res_stall,
    input  wire logic [1:0]                    i_status,
    input  wire logic [lpfd_pkg::BYTE_W-1:0]   i_payload_byte,
    input  wire logic                          i_last,
    input  wire logic                          i_cfg_valid,
    input  wire logic                          i_cfg_ready,
    input  wire logic [lpfd_pkg::LEN_W-1:0]    i_cfg_data,
    output int                                 o_error_count,
    output int                                 o_outstanding
);

    // Decoder state as seen from the accepted transactions.
    logic                           in_payload;
    logic [lpfd_pkg::HDR_CNT_W-1:0] hdr_count;
    logic [lpfd_pkg::LEN_W-1:0]     len_accum;
    logic [lpfd_pkg::LEN_W-1:0]     bytes_left;
    logic [lpfd_pkg::LEN_W-1:0]     max_len;

    lpfd_pkg::t_result expected_results[$];

    task automatic clear_frame();
        in_payload = 1'b0;
        hdr_count  = '0;
        len_accum  = '0;
        bytes_left = '0;
    endtask

    task automatic decode_byte(input lpfd_pkg::t_action act,
                               input logic [lpfd_pkg::BYTE_W-1:0] b);
        lpfd_pkg::t_result r;
        logic              pending;
        r.status       = lpfd_pkg::ST_PAYLOAD;
        r.payload_byte = '0;
        r.last         = 1'b0;
        if (act == lpfd_pkg::ACT_EOS) begin
            pending = in_payload || (hdr_count != '0);
            clear_frame();
            if (pending) begin
                r.status = lpfd_pkg::ST_TRUNCATED;
                expected_results.push_back(r);
            end
        end else if (in_payload) begin
            r.payload_byte = b;
            r.last         = (bytes_left <= 1);
            expected_results.push_back(r);
            if (r.last) begin
                clear_frame();
            end else begin
                bytes_left = bytes_left - 1;
            end
        end else begin
            if (hdr_count < 3'd4) begin
                len_accum = len_accum | (lpfd_pkg::LEN_W'(b) << (8 * hdr_count));
            end
            hdr_count = hdr_count + 1'b1;
            if (hdr_count >= lpfd_pkg::HDR_LAST_CNT) begin
                if (len_accum == '0) begin
                    clear_frame();
                    r.status = lpfd_pkg::ST_EMPTY;
                    expected_results.push_back(r);
                end else if (len_accum > max_len) begin
                    clear_frame();
                    r.status = lpfd_pkg::ST_TOO_LARGE;
                    expected_results.push_back(r);
                end else begin
                    in_payload = 1'b1;
                    bytes_left = len_accum;
                    hdr_count  = '0;
                    len_accum  = '0;
                end
            end
        end
    endtask

    task automatic check_result();
        lpfd_pkg::t_result want;
        if (expected_results.size() == 0) begin
            $display("%0t: unexpected result transaction: status %0d byte 0x%02h last %0d",
                     $time, i_status, i_payload_byte, i_last);
            o_error_count++;
        end else begin
            want = expected_results.pop_front();
            if (i_status !== want.status) begin
                $display("%0t: status mismatch: expected %0d actual %0d",
                         $time, want.status, i_status);
                o_error_count++;
            end
            if (i_payload_byte !== want.payload_byte) begin
                $display("%0t: payload byte mismatch: expected 0x%02h actual 0x%02h",
                         $time, want.payload_byte, i_payload_byte);
                o_error_count++;
            end
            if (i_last !== want.last) begin
                $display("%0t: last flag mismatch: expected %0d actual %0d",
                         $time, want.last, i_last);
                o_error_count++;
            end
        end
    endtask

    initial begin
        o_error_count = 0;
        o_outstanding = 0;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_frame();
            max_len = lpfd_pkg::MAX_LEN_RESET;
            expected_results.delete();
        end else begin
            // A result leaving this cycle belongs to an earlier byte, so it is
            // compared before the byte accepted at the same edge is predicted.
            if (i_res_valid && !i_res_stall) begin
                check_result();
            end
            if (i_byte_valid && !i_byte_stall) begin
                decode_byte(lpfd_pkg::t_action'(i_action), i_data_byte);
            end
            if (i_cfg_valid && i_cfg_ready) begin
                max_len = i_cfg_data;
            end
        end
        o_outstanding = expected_results.size();
    end

endmodule

// ===== dv/length_prefixed_frame_decoder_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed frame decoder testbench
// Drives framed byte streams (good frames, empty and oversized lengths, cut
// headers and payloads, stray bytes) under several maximum-length settings,
// with bursty input and a stalling receiver; the checker judges the results.
// ----------------------------------------------------------------------------

module length_prefixed_frame_decoder_tb;

    localparam int PIPE_FLUSH_CYCLES = 4;
    localparam int WATCHDOG_LIMIT    = 2000;
    localparam int PHASE_ITEMS       = 90;

    logic                          clk;
    logic                          rst_n;
    logic                          byte_valid;
    logic                          byte_stall;
    logic                          action;
    logic [lpfd_pkg::BYTE_W-1:0]   data_byte;
    logic                          res_valid;
    logic                          res_stall;
    logic [1:0]                    res_status;
    logic [lpfd_pkg::BYTE_W-1:0]   res_byte;
    logic                          res_last;
    logic                          cfg_valid;
    logic                          cfg_ready;
    logic [lpfd_pkg::LEN_W-1:0]    cfg_data;
    int                            error_count;
    int                            outstanding;

    int                            items_sent;
    int                            results_seen;
    int                            quiet_cycles;
    int                            settings_used;
    int                            burst_left;
    int                            gap_max;
    logic [lpfd_pkg::LEN_W-1:0]    max_len_cfg;

    length_prefixed_frame_decoder dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_valid        (byte_valid),
        .o_stall        (byte_stall),
        .i_action       (action),
        .i_data_byte    (data_byte),
        .o_valid        (res_valid),
        .i_stall        (res_stall),
        .o_status       (res_status),
        .o_payload_byte (res_byte),
        .o_last         (res_last),
        .i_cfg_valid    (cfg_valid),
        .o_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data)
    );

    frame_decode_checker checker_inst (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_byte_valid   (byte_valid),
        .i_byte_stall   (byte_stall),
        .i_action       (action),
        .i_data_byte    (data_byte),
        .i_res_valid    (res_valid),
        .i_res_stall    (res_stall),
        .i_status       (res_status),
        .i_payload_byte (res_byte),
        .i_last         (res_last),
        .i_cfg_valid    (cfg_valid),
        .i_cfg_ready    (cfg_ready),
        .i_cfg_data     (cfg_data),
        .o_error_count  (error_count),
        .o_outstanding  (outstanding)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: switches between no stall, light, heavy and long stall runs.
    initial begin : receiver
        int   stall_mode;
        int   mode_left;
        int   hold;
        logic level;
        stall_mode = 0;
        mode_left  = 0;
        hold       = 0;
        level      = 1'b0;
        res_stall <= 1'b0;
        forever begin
            @(posedge clk);
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left  = $urandom_range(50, 250);
            end
            mode_left--;
            case (stall_mode)
                0: res_stall <= 1'b0;
                1: res_stall <= ($urandom_range(0, 3) == 0);
                2: res_stall <= ($urandom_range(0, 9) < 7);
                default: begin
                    if (hold == 0) begin
                        hold  = $urandom_range(1, 12);
                        level = ~level;
                    end
                    hold--;
                    res_stall <= level;
                end
            endcase
        end
    end

    // Watchdog: ends the run when no transaction of any kind moves for too long.
    always @(posedge clk) begin
        if (rst_n) begin
            if (res_valid && !res_stall) begin
                results_seen++;
            end
            if ((byte_valid && !byte_stall) || (res_valid && !res_stall)
                    || (cfg_valid && cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic send_item(input lpfd_pkg::t_action act,
                             input logic [lpfd_pkg::BYTE_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
            if (gap > 0) begin
                byte_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        byte_valid <= 1'b1;
        action     <= act;
        data_byte  <= b;
        do @(posedge clk); while (!(byte_valid && !byte_stall));
        items_sent++;
    endtask

    task automatic send_data();
        send_item(lpfd_pkg::ACT_DATA, lpfd_pkg::BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic send_eos();
        send_item(lpfd_pkg::ACT_EOS, lpfd_pkg::BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic send_header(input logic [lpfd_pkg::LEN_W-1:0] len);
        for (int k = 0; k < lpfd_pkg::HEADER_BYTES; k++) begin
            send_item(lpfd_pkg::ACT_DATA, len[8*k +: 8]);
        end
    endtask

    task automatic send_frame(input logic [lpfd_pkg::LEN_W-1:0] len);
        send_header(len);
        repeat (len) send_data();
    endtask

    // Holds the sender off until every expected result has arrived, then lets
    // any header bytes still in the pipeline settle.
    task automatic wait_for_drain();
        byte_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (outstanding != 0);
        repeat (PIPE_FLUSH_CYCLES) @(posedge clk);
    endtask

    task automatic write_max_len(input logic [lpfd_pkg::LEN_W-1:0] value);
        wait_for_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        max_len_cfg = value;
        settings_used++;
    endtask

    function automatic logic [lpfd_pkg::LEN_W-1:0] pick_frame_len();
        logic [lpfd_pkg::LEN_W-1:0] upper;
        upper = (max_len_cfg < 12) ? max_len_cfg : lpfd_pkg::LEN_W'(12);
        if (max_len_cfg >= 40 && $urandom_range(0, 9) == 0) begin
            upper = lpfd_pkg::LEN_W'(40);
        end
        return lpfd_pkg::LEN_W'($urandom_range(1, upper));
    endfunction

    // Only called while the maximum is below 2^32-1.
    function automatic logic [lpfd_pkg::LEN_W-1:0] pick_oversize_len();
        logic [lpfd_pkg::LEN_W-1:0] v;
        v = $urandom;
        if ($urandom_range(0, 1) == 0 || v <= max_len_cfg) begin
            v = max_len_cfg + 1'b1;
        end
        return v;
    endfunction

    task automatic run_traffic(input int target);
        int                         kind;
        logic [lpfd_pkg::LEN_W-1:0] len;
        while (items_sent < target) begin
            kind = $urandom_range(0, 99);
            // With a zero maximum every nonzero length is rejected.
            if (max_len_cfg == '0 && kind < 70) begin
                kind = 80;
            end
            if (kind < 60) begin
                send_frame(pick_frame_len());
            end else if (kind < 70) begin
                if ($urandom_range(0, 2) == 0) begin
                    repeat ($urandom_range(1, lpfd_pkg::HEADER_BYTES - 1)) send_data();
                end else begin
                    len = pick_frame_len();
                    send_header(len);
                    repeat ($urandom_range(0, len - 1)) send_data();
                end
                send_eos();
            end else if (kind < 78) begin
                send_header('0);
            end else if (kind < 88) begin
                if (max_len_cfg != '1) begin
                    send_header(pick_oversize_len());
                end else begin
                    // Nothing is oversized here; open a huge frame and cut it.
                    len = ($urandom_range(0, 1) == 0) ? '1 : ($urandom | 32'h8000_0000);
                    send_header(len);
                    repeat ($urandom_range(0, 6)) send_data();
                    send_eos();
                end
            end else if (kind < 94) begin
                send_eos();
            end else begin
                // Stray bytes knock the header out of step; the end of stream
                // brings the decoder back to a clean state.
                repeat ($urandom_range(1, 5)) send_data();
                send_eos();
            end
            if ($urandom_range(0, 49) == 0) begin
                wait_for_drain();
            end
        end
    endtask

    initial begin : stimulus
        logic [lpfd_pkg::LEN_W-1:0] settings[6];
        settings      = '{32'd1, 32'd0, 32'hFFFF_FFFF, 32'd5, 32'd40,
                          lpfd_pkg::MAX_LEN_RESET};
        items_sent    = 0;
        results_seen  = 0;
        quiet_cycles  = 0;
        settings_used = 1;
        burst_left    = 0;
        gap_max       = 3;
        max_len_cfg   = lpfd_pkg::MAX_LEN_RESET;
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        action     <= lpfd_pkg::ACT_DATA;
        data_byte  <= '0;
        cfg_valid  <= 1'b0;
        cfg_data   <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset maximum.
        send_eos();
        send_header('0);
        send_header(32'd1);
        send_item(lpfd_pkg::ACT_DATA, 8'hFF);
        send_header(32'h0010_0001);
        send_header(lpfd_pkg::MAX_LEN_RESET);
        send_item(lpfd_pkg::ACT_DATA, 8'h00);
        send_item(lpfd_pkg::ACT_DATA, 8'hA5);
        send_eos();
        send_item(lpfd_pkg::ACT_DATA, 8'h5A);
        send_item(lpfd_pkg::ACT_DATA, 8'hC3);
        send_eos();

        run_traffic(items_sent + PHASE_ITEMS);
        for (int p = 0; p < 6; p++) begin
            write_max_len(settings[p]);
            case (p % 3)
                0: gap_max = 0;
                1: gap_max = 3;
                default: gap_max = 8;
            endcase
            run_traffic(items_sent + PHASE_ITEMS);
        end
        wait_for_drain();

        $display("Sent %0d byte and end-of-stream transactions under %0d maximum lengths",
                 items_sent, settings_used);
        $display("(0, 1 and 2^32-1 among them); compared %0d result transactions.",
                 results_seen);
        if (error_count == 0 && outstanding == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("%0t: %0d mismatches, %0d results never arrived",
                     $time, error_count, outstanding);
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
